>>> src/mgts_pkg.sv
package mgts_pkg;

	localparam int WINDOW = 15;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int DW = 24;
	localparam int WW = 17;
	localparam int TW = 23;
	localparam logic [WW-1:0] ONE_Q16 = 17'd65536;
	localparam logic [WW-1:0] ALPHA_RST = 17'd26214;
	localparam logic [WW-1:0] GAMMA_RST = 17'd39322;
	localparam logic [TW-1:0] JIT_RST = 23'd32768;

	// register indexes
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_GAMMA = 2'd1;
	localparam logic [1:0] REG_JIT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK,
		ST_GATE,
		ST_TREND,
		ST_OUT
	} state_t;

	// controls from the sequencer to each lane
	typedef struct packed {
		logic load;
		logic [SLOT_W-1:0] slot;
		logic rank;
		logic [SLOT_W-1:0] cand;
		logic gate;
		logic trend;
	} lane_ctl_t;

	// saturate a 64 bit value to 24 bit signed
	function automatic logic signed [DW-1:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -64'sd8388608)
			return 24'sh800000;
		else
			return v[DW-1:0];
	endfunction

	// weighted blend rounded to nearest, ties upward, then saturated
	function automatic logic signed [DW-1:0] blend(input logic [WW-1:0] w,
			input logic signed [25:0] a, input logic signed [25:0] b);
		logic [WW-1:0] wc;
		logic signed [63:0] s;
		wc = (w > ONE_Q16) ? ONE_Q16 : w;
		s = $signed({47'd0, wc}) * 64'(a)
			+ $signed({47'd0, ONE_Q16 - wc}) * 64'(b) + 64'sd32768;
		return sat24(s >>> 16);
	endfunction

endpackage

>>> src/mgts_lane.sv
module mgts_lane import mgts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  lane_ctl_t ctl,
	input  logic signed [DW-1:0] sample,
	input  logic [WW-1:0] alpha,
	input  logic [WW-1:0] gamma,
	input  logic [TW-1:0] jit,
	output logic signed [DW-1:0] result
);

	logic signed [DW-1:0] win_q [WINDOW];
	logic signed [DW-1:0] samp_q, med_q, out_q, trend_q, prev_q;
	logic found_q;
	logic [CNT_W-1:0] below, not_above;
	logic signed [DW-1:0] cv;
	logic signed [DW:0] gap;

	// rank count of one candidate against the whole window
	always_comb begin
		cv = win_q[ctl.cand];
		below = '0;
		not_above = '0;
		for (int j = 0; j < WINDOW; j++) begin
			below = below + CNT_W'(win_q[j] < cv);
			not_above = not_above + CNT_W'(win_q[j] <= cv);
		end
		gap = {samp_q[DW-1], samp_q} - {med_q[DW-1], med_q};
		if (gap < 0)
			gap = -gap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				win_q[i] <= '0;
			out_q <= '0;
			trend_q <= '0;
			med_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				win_q[ctl.slot] <= sample;
				found_q <= 1'b0;
			end
			if (ctl.rank && !found_q && below <= CNT_W'(WINDOW / 2)
					&& CNT_W'(WINDOW / 2) < not_above) begin
				found_q <= 1'b1;
				med_q <= cv;
			end
			// gate: median beyond threshold, Holt level otherwise
			if (ctl.gate) begin
				if (gap > $signed({2'b0, jit}))
					out_q <= med_q;
				else
					out_q <= blend(alpha, 26'(samp_q), 26'(out_q) + 26'(trend_q));
			end
			if (ctl.trend)
				trend_q <= blend(gamma, 26'(result) - 26'(prev_q), 26'(trend_q));
		end
	end

	// sample and previous output held for the gate and trend steps
	always_ff @(posedge clk) begin
		if (ctl.load)
			samp_q <= sample;
		if (ctl.gate)
			prev_q <= out_q;
	end

	assign result = out_q;

endmodule

>>> src/median_gated_trend_smoother_top.sv
// Two-axis gaze smoother: each coordinate runs in its own lane with a fifteen-entry
// sliding window, a median gate and a Holt level/trend update. A request passes through
// the core in order: the accepting cycle loads the sample, the median rank search then
// steps through every window entry, then come the gate and trend steps and a hand-over
// cycle into the output register. The hand-over writes the result into the output
// register, which drives m_tvalid, and the next request is accepted from the cycle
// after the hand-over. The output register holds a result until taken; the core waits
// in the hand-over cycle only while an earlier result is still held there.
module median_gated_trend_smoother_top import mgts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [TW-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [47:0] s_tdata,   // x_in[23:0], y_in[47:24]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata    // x_out[23:0], y_out[47:24]
);

	logic [WW-1:0] alpha_q, gamma_q;
	logic [TW-1:0] jit_q;
	state_t st_q, st_d;
	logic [SLOT_W-1:0] slot_q, cand_q;
	lane_ctl_t ctl;
	logic signed [DW-1:0] xr, yr;
	logic [47:0] res_q;
	logic res_v_q;
	logic push_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			gamma_q <= GAMMA_RST;
			jit_q <= JIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[WW-1:0];
				REG_GAMMA: gamma_q <= cfg_data[WW-1:0];
				REG_JIT:   jit_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			slot_q <= '0;
			cand_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_RANK)
				cand_q <= (cand_q == SLOT_W'(WINDOW - 1)) ? '0 : cand_q + 1'b1;
			if (ctl.load)
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// output register, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			res_v_q <= 1'b0;
		end else if (push_res) begin
			res_q <= {yr, xr};
			res_v_q <= 1'b1;
		end else if (m_tready) begin
			res_v_q <= 1'b0;
		end
	end

	// sequencer
	always_comb begin
		st_d = st_q;
		ctl = '0;
		ctl.slot = slot_q;
		ctl.cand = cand_q;
		s_tready = 1'b0;
		push_res = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					st_d = ST_RANK;
				end
			end
			ST_RANK: begin
				ctl.rank = 1'b1;
				if (cand_q == SLOT_W'(WINDOW - 1))
					st_d = ST_GATE;
			end
			ST_GATE: begin
				ctl.gate = 1'b1;
				st_d = ST_TREND;
			end
			ST_TREND: begin
				ctl.trend = 1'b1;
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_v_q || m_tready) begin
					push_res = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	mgts_lane u_x (.clk, .arst_n, .ctl, .sample(s_tdata[23:0]), .alpha(alpha_q),
		.gamma(gamma_q), .jit(jit_q), .result(xr));
	mgts_lane u_y (.clk, .arst_n, .ctl, .sample(s_tdata[47:24]), .alpha(alpha_q),
		.gamma(gamma_q), .jit(jit_q), .result(yr));

	assign m_tvalid = res_v_q;
	assign m_tdata = res_q;

endmodule
